// ----- design/erc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants for the event ring
// Field widths, function codes, controller state and control/status groups.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_W         = 32;
    localparam int DATA_W       = 64;
    localparam int COUNT_W      = 7;

    localparam logic [ID_W-1:0] FIRST_ID = 32'd1;

    localparam logic FUNC_PUBLISH = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DONE
    } erc_state_t;

    typedef struct packed {
        logic ready;
        logic take;
        logic rd;
        logic load;
    } erc_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic req_func;
        logic out_free;
    } erc_sts_t;

endpackage
`default_nettype wire

// ----- design/erc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erc_if: word channels of the event ring
// Request channel (publish / read) and response channel, valid-ready.
// ----------------------------------------------------------------------------
interface erc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [erc_pkg::DATA_W-1:0]  record_data;
    logic [erc_pkg::ID_W-1:0]    cursor;

    modport source (output valid, output func, output record_data, output cursor,
                    input ready);
    modport sink   (input valid, input func, input record_data, input cursor,
                    output ready);
endinterface

interface erc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic                        gap;
    logic [erc_pkg::ID_W-1:0]    next_cursor;
    logic [erc_pkg::ID_W-1:0]    event_id;
    logic [erc_pkg::DATA_W-1:0]  event_data;
    logic [erc_pkg::ID_W-1:0]    oldest_id;
    logic [erc_pkg::ID_W-1:0]    latest_id;
    logic [erc_pkg::COUNT_W-1:0] stored_count;

    modport source (output valid, output found, output gap, output next_cursor,
                    output event_id, output event_data, output oldest_id,
                    output latest_id, output stored_count, input ready);
    modport sink   (input valid, input found, input gap, input next_cursor,
                    input event_id, input event_data, input oldest_id,
                    input latest_id, input stored_count, output ready);
endinterface
`default_nettype wire

// ----- design/erc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erc_ctrl: item sequencer
// Takes one word, steps through ring lookup for reads, hands the result off.
// ----------------------------------------------------------------------------
module erc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire erc_pkg::erc_sts_t sts,
    output erc_pkg::erc_cmd_t     cmd
);

    erc_pkg::erc_state_t state_reg;
    erc_pkg::erc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            erc_pkg::ST_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = (sts.req_func == erc_pkg::FUNC_READ) ? erc_pkg::ST_ADDR
                                                                       : erc_pkg::ST_DONE;
                end
            end
            erc_pkg::ST_ADDR:
            begin
                state_next = erc_pkg::ST_DONE;
            end
            erc_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = erc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = erc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            erc_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.take  = sts.req_valid;
            end
            erc_pkg::ST_ADDR:
            begin
                cmd.rd = 1'b1;
            end
            erc_pkg::ST_DONE:
            begin
                cmd.load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/erc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erc_dp: ring storage, id counters and result register
// Holds the entry memory, the sequence/slot bookkeeping and the output word.
// ----------------------------------------------------------------------------
module erc_dp #(
    parameter int CAPACITY = erc_pkg::CAPACITY_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire erc_pkg::erc_cmd_t            cmd,
    input  wire logic                         req_func,
    input  wire logic [erc_pkg::DATA_W-1:0]   req_record_data,
    input  wire logic [erc_pkg::ID_W-1:0]     req_cursor,
    input  wire logic                         rsp_ready,
    output logic                              out_free,
    output logic                              rsp_valid,
    output logic                              rsp_found,
    output logic                              rsp_gap,
    output logic [erc_pkg::ID_W-1:0]          rsp_next_cursor,
    output logic [erc_pkg::ID_W-1:0]          rsp_event_id,
    output logic [erc_pkg::DATA_W-1:0]        rsp_event_data,
    output logic [erc_pkg::ID_W-1:0]          rsp_oldest_id,
    output logic [erc_pkg::ID_W-1:0]          rsp_latest_id,
    output logic [erc_pkg::COUNT_W-1:0]       rsp_stored_count
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = erc_pkg::ID_W;
    localparam int DW = erc_pkg::DATA_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);
    localparam logic [SW:0]   CAP_EXT   = (SW + 1)'(CAPACITY);

    // ring memory: {id, record}
    logic [IW+DW-1:0] mem [CAPACITY];

    // bookkeeping
    logic [IW-1:0] next_id_reg;
    logic [IW-1:0] oldest_reg;
    logic [IW-1:0] latest_reg;
    logic [CW-1:0] held_reg;
    logic [SW-1:0] wr_slot_reg;
    logic [SW-1:0] old_slot_reg;

    // item in flight
    logic          func_reg;
    logic          gap_reg;
    logic          hit_reg;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] pid_reg;
    logic [SW-1:0] off_reg;
    logic [IW-1:0] rd_id_reg;
    logic [DW-1:0] rd_data_reg;

    // output word
    logic          out_valid_reg;
    logic          out_found_reg;
    logic          out_gap_reg;
    logic [IW-1:0] out_cursor_reg;
    logic [IW-1:0] out_id_reg;
    logic [DW-1:0] out_data_reg;
    logic [IW-1:0] out_oldest_reg;
    logic [IW-1:0] out_latest_reg;
    logic [CW-1:0] out_count_reg;

    logic          publish;
    logic          nonempty;
    logic          full;
    logic [IW-1:0] cur_p1;
    logic [IW-1:0] oldest_m1;
    logic [SW-1:0] span;
    logic          behind;
    logic          hit;
    logic [IW-1:0] adj;
    logic [SW-1:0] off;
    logic [SW:0]   idx_sum;
    logic [SW-1:0] rd_idx;
    logic [SW-1:0] wr_slot_inc;
    logic [SW-1:0] old_slot_inc;

    assign publish   = cmd.take && (req_func == erc_pkg::FUNC_PUBLISH);
    assign nonempty  = (held_reg != '0);
    assign full      = (held_reg == FULL_CNT);
    assign cur_p1    = req_cursor + 1'b1;
    assign oldest_m1 = oldest_reg - 1'b1;
    assign span      = SW'(cur_p1 - oldest_reg);
    assign behind    = nonempty && (cur_p1 < oldest_reg);
    assign adj       = behind ? oldest_m1 : req_cursor;
    assign hit       = nonempty && (behind ? (oldest_m1 < latest_reg)
                                           : (req_cursor < latest_reg));
    // a hit always lands less than held_count past the oldest id
    assign off       = behind ? '0 : span;

    assign idx_sum   = {1'b0, old_slot_reg} + {1'b0, off_reg};
    assign rd_idx    = (idx_sum >= CAP_EXT) ? SW'(idx_sum - CAP_EXT) : idx_sum[SW-1:0];

    assign wr_slot_inc  = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
    assign old_slot_inc = (old_slot_reg == LAST_SLOT) ? '0 : old_slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg  <= erc_pkg::FIRST_ID;
            oldest_reg   <= erc_pkg::FIRST_ID;
            latest_reg   <= '0;
            held_reg     <= '0;
            wr_slot_reg  <= '0;
            old_slot_reg <= '0;
        end
        else if (publish)
        begin
            next_id_reg <= next_id_reg + 1'b1;
            latest_reg  <= next_id_reg;
            wr_slot_reg <= wr_slot_inc;
            if (full)
            begin
                oldest_reg   <= oldest_reg + 1'b1;
                old_slot_reg <= old_slot_inc;
            end
            else
            begin
                held_reg <= held_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg <= req_func;
            pid_reg  <= next_id_reg;
            off_reg  <= off;
            if (req_func == erc_pkg::FUNC_READ)
            begin
                gap_reg <= behind;
                hit_reg <= hit;
                cur_reg <= adj;
            end
            else
            begin
                gap_reg <= 1'b0;
                hit_reg <= 1'b0;
                cur_reg <= req_cursor;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            mem[wr_slot_reg] <= {next_id_reg, req_record_data};
        end
        if (cmd.rd)
        begin
            {rd_id_reg, rd_data_reg} <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_found_reg  <= hit_reg;
            out_gap_reg    <= gap_reg;
            out_cursor_reg <= hit_reg ? rd_id_reg : cur_reg;
            if (hit_reg)
            begin
                out_id_reg <= rd_id_reg;
            end
            else if (func_reg == erc_pkg::FUNC_PUBLISH)
            begin
                out_id_reg <= pid_reg;
            end
            else
            begin
                out_id_reg <= '0;
            end
            out_data_reg   <= hit_reg ? rd_data_reg : '0;
            out_oldest_reg <= oldest_reg;
            out_latest_reg <= latest_reg;
            out_count_reg  <= held_reg;
        end
    end

    assign out_free         = !out_valid_reg || rsp_ready;
    assign rsp_valid        = out_valid_reg;
    assign rsp_found        = out_found_reg;
    assign rsp_gap          = out_gap_reg;
    assign rsp_next_cursor  = out_cursor_reg;
    assign rsp_event_id     = out_id_reg;
    assign rsp_event_data   = out_data_reg;
    assign rsp_oldest_id    = out_oldest_reg;
    assign rsp_latest_id    = out_latest_reg;
    assign rsp_stored_count = erc_pkg::COUNT_W'(out_count_reg);

endmodule
`default_nettype wire

// ----- design/event_ring_with_cursor_reads.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// event_ring_with_cursor_reads: overwriting event log with cursor reads
// Publish stores a record under the next sequence id; read returns the event
// after a reader cursor, flagging a gap when the cursor fell behind.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  req      in   valid/ready   func, record_data, cursor
//  rsp      out  valid/ready   found, gap, next_cursor, event_id, event_data,
//                              oldest_id, latest_id, stored_count
//
//  One word in flight at a time. Publish steps from ST_IDLE (accept) to ST_DONE, which
//  loads the output register; read passes ST_IDLE, ST_ADDR (the registered ring
//  memory read) and ST_DONE. The next word is taken back in ST_IDLE.
//  The output register lets the next word be accepted while a result waits;
//  that word then holds in the last controller state until rsp.ready frees it.
//  Reset clears counters and control; ring entries stay undefined until written.
// ----------------------------------------------------------------------------
module event_ring_with_cursor_reads #(
    parameter int CAPACITY = erc_pkg::CAPACITY_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    erc_req_if.sink   req,
    erc_rsp_if.source rsp
);

    erc_pkg::erc_cmd_t cmd;
    erc_pkg::erc_sts_t sts;
    logic              out_free;

    assign sts.req_valid = req.valid;
    assign sts.req_func  = req.func;
    assign sts.out_free  = out_free;
    assign req.ready     = cmd.ready;

    erc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    erc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .req_func         (req.func),
        .req_record_data  (req.record_data),
        .req_cursor       (req.cursor),
        .rsp_ready        (rsp.ready),
        .out_free         (out_free),
        .rsp_valid        (rsp.valid),
        .rsp_found        (rsp.found),
        .rsp_gap          (rsp.gap),
        .rsp_next_cursor  (rsp.next_cursor),
        .rsp_event_id     (rsp.event_id),
        .rsp_event_data   (rsp.event_data),
        .rsp_oldest_id    (rsp.oldest_id),
        .rsp_latest_id    (rsp.latest_id),
        .rsp_stored_count (rsp.stored_count)
    );

    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second word accepted while one is in flight");

    a_found_moves_cursor : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.next_cursor == rsp.event_id))
        else $error("returned event id differs from new cursor");

    a_gap_pulls_cursor : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.gap && !rsp.found) |-> (rsp.next_cursor == rsp.oldest_id - 32'd1))
        else $error("gap without cursor pulled up to oldest");

    a_empty_data : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.event_data == '0))
        else $error("record word on a result without an event");

endmodule
`default_nettype wire
